>>> rtl/core/bphd_pkg.sv
// ----------------------------------------------------------------------------
// bphd_pkg: shared types and constants
// Entry layouts, press states, register indexes and the command and status
// structs between the controller and the datapath of the button classifier.
// ----------------------------------------------------------------------------
package bphd_pkg;

    localparam int NUM_KEYS    = 128;
    localparam int NUM_BUTTONS = 8;
    localparam int KEY_AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    localparam int IDX_W      = 7;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 16;
    localparam int DRAG_W     = 17;
    localparam int DIST_W     = 12;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 72;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_DOUBLE_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HOLD_MS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_DOUBLE_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_HOLD_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_DOUBLE_DIST = 3'd5;

    // input kind codes
    localparam logic KIND_MOUSE = 1'b0;
    localparam logic KIND_KEY   = 1'b1;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_DOUBLE   = 2'd2,
        ST_HELD     = 2'd3
    } press_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_READ,
        CS_CALC,
        CS_SQUARE,
        CS_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic calc;
        logic square;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

    typedef struct packed {
        press_state_t        mode;
        logic [TIME_W-1:0]   press_time;
        logic [TIME_W-1:0]   prev_time;
        logic [TIME_W-1:0]   hold_time;
    } key_row_t;

    typedef struct packed {
        press_state_t        mode;
        logic [TIME_W-1:0]   press_time;
        logic [TIME_W-1:0]   prev_time;
        logic [TIME_W-1:0]   hold_time;
        logic [POS_W-1:0]    click_x;
        logic [POS_W-1:0]    click_y;
    } btn_row_t;

endpackage

>>> rtl/core/button_press_hold_double_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_hold_double_classifier_core: key and mouse button classifier
// Tracks released, pressed, double and held per key and per mouse button.
//
// Usage:
//   Input beats on s_* carry one key or button sample; s_tuser is the kind
//   (0 mouse, 1 key). Each beat yields exactly one result beat on m_*.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wdata; the user
//   must write them only while the block is idle, which it does not enforce.
//   Sequencing: the result beat is presented from the output register, which
//   the decide step loads. The sequencer steps each sample through store
//   read, time compare, distance squaring and the decide and write-back
//   step; one sample is in flight at a time.
//   Stall: a result waits in the output register; the next sample is taken
//   meanwhile and holds in its decide step until that register frees.
//   Reset: all entries read as released with zero times; registers take
//   their defaults (updates on, 300 ms double, 500 ms hold, radius 4).
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module button_press_hold_double_classifier_core
    import bphd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // index[6:0], down[7], now_ms[39:8], pos_x[55:40], pos_y[71:56]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // press_state[1:0], hold_ms[33:2], drag_dx[50:34], drag_dy[67:51], zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    bphd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bphd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> rtl/core/bphd_ctrl.sv
// ----------------------------------------------------------------------------
// bphd_ctrl: item sequencer
// Walks one sample through read, compare, square and decide steps and holds
// the decide step while the output register is still occupied.
// ----------------------------------------------------------------------------
module bphd_ctrl
    import bphd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_READ;
                end
            end
            CS_READ: begin
                cmd.read   = 1'b1;
                state_next = CS_CALC;
            end
            CS_CALC: begin
                cmd.calc   = 1'b1;
                state_next = CS_SQUARE;
            end
            CS_SQUARE: begin
                cmd.square = 1'b1;
                state_next = CS_DECIDE;
            end
            CS_DECIDE: begin
                // hold until the previous result has left
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/bphd_dp.sv
// ----------------------------------------------------------------------------
// bphd_dp: entry stores, timing compares and result register
// Holds the configuration, the key and button entry stores, the distance
// squaring and the state update, plus the output register.
// ----------------------------------------------------------------------------
module bphd_dp
    import bphd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts
);

    // configuration
    logic              upd_en_reg;
    logic [MS_W-1:0]   key_dbl_reg;
    logic [MS_W-1:0]   key_hold_reg;
    logic [MS_W-1:0]   ms_dbl_reg;
    logic [MS_W-1:0]   ms_hold_reg;
    logic [DIST_W-1:0] ms_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_en_reg   <= 1'b1;
            key_dbl_reg  <= 16'd300;
            key_hold_reg <= 16'd500;
            ms_dbl_reg   <= 16'd300;
            ms_hold_reg  <= 16'd500;
            ms_dist_reg  <= 12'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_UPDATE_ENABLE:     upd_en_reg   <= cfg_wdata[0];
                CFG_KEY_DOUBLE_MS:     key_dbl_reg  <= cfg_wdata;
                CFG_KEY_HOLD_MS:       key_hold_reg <= cfg_wdata;
                CFG_MOUSE_DOUBLE_MS:   ms_dbl_reg   <= cfg_wdata;
                CFG_MOUSE_HOLD_MS:     ms_hold_reg  <= cfg_wdata;
                CFG_MOUSE_DOUBLE_DIST: ms_dist_reg  <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // captured sample
    logic              in_kind_reg;
    logic [IDX_W-1:0]  in_index_reg;
    logic              in_down_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic [POS_W-1:0]  in_px_reg;
    logic [POS_W-1:0]  in_py_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_kind_reg  <= s_tuser;
            in_index_reg <= s_tdata[6:0];
            in_down_reg  <= s_tdata[7];
            in_now_reg   <= s_tdata[39:8];
            in_px_reg    <= s_tdata[55:40];
            in_py_reg    <= s_tdata[71:56];
        end
    end

    logic              in_range;
    logic [KEY_AW-1:0] key_addr;
    logic [BTN_AW-1:0] btn_addr;

    assign in_range = (in_kind_reg == KIND_KEY) ? (int'(in_index_reg) < NUM_KEYS)
                                                : (int'(in_index_reg) < NUM_BUTTONS);
    assign key_addr = KEY_AW'(in_index_reg);
    assign btn_addr = BTN_AW'(in_index_reg);

    // entry stores; an entry never written reads as all zero
    key_row_t               key_mem [NUM_KEYS];
    btn_row_t               btn_mem [NUM_BUTTONS];
    logic [NUM_KEYS-1:0]    key_vld_reg;
    logic [NUM_BUTTONS-1:0] btn_vld_reg;
    key_row_t               key_rd_reg;
    btn_row_t               btn_rd_reg;
    logic                   key_rv_reg;
    logic                   btn_rv_reg;
    logic                   key_we;
    logic                   btn_we;
    key_row_t               key_new;
    btn_row_t               btn_new;

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_addr] <= key_new;
        end
        if (cmd.read) begin
            key_rd_reg <= key_mem[key_addr];
            key_rv_reg <= key_vld_reg[key_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (btn_we) begin
            btn_mem[btn_addr] <= btn_new;
        end
        if (cmd.read) begin
            btn_rd_reg <= btn_mem[btn_addr];
            btn_rv_reg <= btn_vld_reg[btn_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_vld_reg <= '0;
            btn_vld_reg <= '0;
        end else begin
            if (key_we) key_vld_reg[key_addr] <= 1'b1;
            if (btn_we) btn_vld_reg[btn_addr] <= 1'b1;
        end
    end

    // compare step: select the entry, form time gaps and position deltas
    btn_row_t          cur_row;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] gap;
    logic [MS_W-1:0]   hold_lim;
    logic [MS_W-1:0]   dbl_lim;

    always_comb begin
        if (in_kind_reg == KIND_KEY) begin
            cur_row            = '0;
            if (key_rv_reg) begin
                cur_row.mode       = key_rd_reg.mode;
                cur_row.press_time = key_rd_reg.press_time;
                cur_row.prev_time  = key_rd_reg.prev_time;
                cur_row.hold_time  = key_rd_reg.hold_time;
            end
            hold_lim = key_hold_reg;
            dbl_lim  = key_dbl_reg;
        end else begin
            cur_row  = btn_rv_reg ? btn_rd_reg : '0;
            hold_lim = ms_hold_reg;
            dbl_lim  = ms_dbl_reg;
        end
        age = in_now_reg - cur_row.press_time;
        gap = cur_row.press_time - cur_row.prev_time;
    end

    btn_row_t                  cur_reg;
    logic [TIME_W-1:0]         age_reg;
    logic                      hold_hit_reg;
    logic                      gap_hit_reg;
    logic signed [DRAG_W-1:0]  dx_reg;
    logic signed [DRAG_W-1:0]  dy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            cur_reg      <= cur_row;
            age_reg      <= age;
            hold_hit_reg <= age >= {16'd0, hold_lim};
            gap_hit_reg  <= gap < {16'd0, dbl_lim};
            dx_reg       <= signed'({in_px_reg[POS_W-1], in_px_reg})
                          - signed'({cur_row.click_x[POS_W-1], cur_row.click_x});
            dy_reg       <= signed'({in_py_reg[POS_W-1], in_py_reg})
                          - signed'({cur_row.click_y[POS_W-1], cur_row.click_y});
        end
    end

    // square step
    logic signed [2*DRAG_W-1:0] sq_x_full;
    logic signed [2*DRAG_W-1:0] sq_y_full;
    logic [2*DRAG_W-2:0]        sq_x_reg;
    logic [2*DRAG_W-2:0]        sq_y_reg;
    logic [2*DIST_W-1:0]        r2_reg;

    assign sq_x_full = (2*DRAG_W)'(dx_reg) * (2*DRAG_W)'(dx_reg);
    assign sq_y_full = (2*DRAG_W)'(dy_reg) * (2*DRAG_W)'(dy_reg);

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_x_reg <= sq_x_full[2*DRAG_W-2:0];
            sq_y_reg <= sq_y_full[2*DRAG_W-2:0];
            r2_reg   <= {{DIST_W{1'b0}}, ms_dist_reg} * {{DIST_W{1'b0}}, ms_dist_reg};
        end
    end

    // decide step
    logic [2*DRAG_W-1:0] dist_sum;
    logic                dist_hit;
    logic                dbl_hit;
    press_state_t        mode_new;
    press_state_t        out_state;
    logic [TIME_W-1:0]   out_hold;
    logic                do_write;

    assign dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign dist_hit = dist_sum < {{(2*DRAG_W-2*DIST_W){1'b0}}, r2_reg};
    assign dbl_hit  = gap_hit_reg && ((in_kind_reg == KIND_KEY) || dist_hit);

    always_comb begin
        mode_new = cur_reg.mode;
        if (!in_down_reg) begin
            mode_new = ST_RELEASED;
        end else begin
            unique case (cur_reg.mode)
                ST_RELEASED: mode_new = ST_PRESSED;
                ST_PRESSED:  mode_new = hold_hit_reg ? ST_HELD
                                      : (dbl_hit ? ST_DOUBLE : ST_PRESSED);
                ST_DOUBLE:   mode_new = hold_hit_reg ? ST_HELD : ST_DOUBLE;
                ST_HELD:     mode_new = ST_HELD;
                default:     mode_new = ST_RELEASED;
            endcase
        end
    end

    always_comb begin
        btn_new      = cur_reg;
        btn_new.mode = mode_new;
        if (!in_down_reg) begin
            btn_new.click_x = '0;
            btn_new.click_y = '0;
        end else if (cur_reg.mode == ST_RELEASED) begin
            btn_new.press_time = in_now_reg;
            btn_new.prev_time  = cur_reg.press_time;
            btn_new.click_x    = in_px_reg;
            btn_new.click_y    = in_py_reg;
        end
        if (mode_new == ST_HELD) begin
            btn_new.hold_time = age_reg;
        end
        key_new.mode       = btn_new.mode;
        key_new.press_time = btn_new.press_time;
        key_new.prev_time  = btn_new.prev_time;
        key_new.hold_time  = btn_new.hold_time;
    end

    assign do_write  = cmd.commit && upd_en_reg && in_range;
    assign key_we    = do_write && (in_kind_reg == KIND_KEY);
    assign btn_we    = do_write && (in_kind_reg == KIND_MOUSE);
    assign out_state = upd_en_reg ? mode_new : cur_reg.mode;
    assign out_hold  = upd_en_reg ? btn_new.hold_time : cur_reg.hold_time;

    // output register
    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 show_drag;

    assign show_drag = (in_kind_reg == KIND_MOUSE) && (out_state == ST_HELD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (!in_range) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {4'd0,
                                 show_drag ? dy_reg : {DRAG_W{1'b0}},
                                 show_drag ? dx_reg : {DRAG_W{1'b0}},
                                 out_hold,
                                 out_state};
            end
        end
    end

    assign sts.out_free = !out_vld_reg || m_tready;
    assign m_tvalid     = out_vld_reg;
    assign m_tdata      = out_data_reg;

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("result committed while output register occupied");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_vld_reg)
        else $error("committed result not presented");

    a_key_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        key_we |=> key_vld_reg[$past(key_addr)])
        else $error("written key entry not marked valid");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !in_range) |=> (m_tdata == '0))
        else $error("out of range sample gave nonzero result");

endmodule
